// ===== rtl/core/tmn_pkg.sv =====
// Package: shared types and constants for the triangular matrix norm core.
`timescale 1ns / 1ps
`default_nettype none
package tmn_pkg;
  localparam int MAX_DIM_DEF   = 64;
  localparam int ELEM_BITS_DEF = 16;
  localparam int NORM_W        = 22;
  localparam int SQ_W          = 44;
  localparam int DIM_W         = 7;
  localparam int IDX_W         = 3;
  localparam logic [NORM_W-1:0] NORM_MAX = {NORM_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_MAX_MAG = 2'd0,
    KIND_COL_SUM = 2'd1,
    KIND_ROW_SUM = 2'd2,
    KIND_FROB    = 2'd3
  } kind_t;

  typedef enum logic [IDX_W-1:0] {
    REG_NORM_KIND  = 3'd0,
    REG_LOWER_PART = 3'd1,
    REG_UNIT_DIAG  = 3'd2,
    REG_ROW_COUNT  = 3'd3,
    REG_COL_COUNT  = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAG,
    ST_ACC,
    ST_ROWRD,
    ST_ROWWR,
    ST_FROB,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } sqrt_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/core/tmn_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module tmn_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/tmn_isqrt.sv =====
// Digit-serial integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
`default_nettype none
module tmn_isqrt #(
  parameter int IN_W = 44
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [IN_W-1:0]   radicand,
  output logic [IN_W/2-1:0]      root,
  output logic                   busy,
  output logic                   done
);
  localparam int HALF  = IN_W / 2;
  localparam int CNT_W = $clog2(HALF + 1);

  logic [IN_W-1:0]  rad;
  logic [HALF+1:0]  rem;
  logic [HALF-1:0]  res;
  logic [CNT_W-1:0] cnt;
  logic [HALF+1:0]  trial;
  logic [HALF+1:0]  shifted;

  always_comb begin
    shifted = {rem[HALF-1:0], rad[IN_W-1 -: 2]};
    trial   = {res, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(HALF);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad <= radicand;
      rem <= '0;
      res <= '0;
    end else if (busy) begin
      rad <= {rad[IN_W-3:0], 2'b00};
      if (shifted >= trial) begin
        rem <= shifted - trial;
        res <= {res[HALF-2:0], 1'b1};
      end else begin
        rem <= shifted;
        res <= {res[HALF-2:0], 1'b0};
      end
    end
  end

  assign root = res;
endmodule
`default_nettype wire

// ===== rtl/core/triangular_matrix_norm_core.sv =====
// Top level: triangular/trapezoidal complex matrix norm core.
`timescale 1ns / 1ps
`default_nettype none
// Elements arrive column-major, one at a time: the core takes a new element
// only once it is through with the last. The two-bit-per-cycle square root of
// re^2+im^2 runs SQ_W/2 steps, one for each root bit. Then come its done strobe,
// the row-total memory read, the accumulate and write step, and the idle state
// in which the next element is taken. After the last element of a matrix the
// result moves into the output register; a Frobenius result first takes a
// further pass through the same root unit. One word per matrix leaves on the
// output and is held there under stall while the next matrix streams in.
// Input stalls whenever the core is not idle or cfg_valid is high, so also
// while a result waits for the previous one to leave.
module triangular_matrix_norm_core #(
  parameter int MAX_DIM   = tmn_pkg::MAX_DIM_DEF,
  parameter int ELEM_BITS = tmn_pkg::ELEM_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic signed [ELEM_BITS-1:0]     elem_re,
  input  wire logic signed [ELEM_BITS-1:0]     elem_im,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [tmn_pkg::NORM_W-1:0]           norm_value,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [tmn_pkg::IDX_W-1:0]       cfg_index,
  input  wire logic [31:0]                     cfg_data
);
  localparam int NW  = tmn_pkg::NORM_W;
  localparam int SW  = tmn_pkg::SQ_W;
  localparam int PW  = $clog2(MAX_DIM) > 0 ? $clog2(MAX_DIM) : 1;
  localparam int DW  = tmn_pkg::DIM_W;
  localparam int EW  = ELEM_BITS;

  tmn_pkg::state_t state, state_next;
  tmn_pkg::kind_t  kind;
  logic            lower, unitd;
  logic [DW-1:0]   row_cnt, col_cnt;
  logic [PW-1:0]   row_pos, col_pos;
  logic [NW-1:0]   best, col_tot, mag;
  logic [SW-1:0]   sq_tot, sq, sq_term;
  logic [EW-1:0]   are, aim;
  logic [2*EW-1:0] are_sq, aim_sq;
  logic [2*EW:0]   sq_el;
  logic            restart;
  logic [PW-1:0]   rows_m1, cols_m1;
  logic            counted, diag, last_row, last_col;
  logic [NW:0]     col_sum, row_sum;
  logic [NW-1:0]   row_rd, row_wr;
  logic [NW-1:0]   col_fin, best_next;
  logic [SW:0]     sq_sum;
  logic [SW-1:0]   sq_fin;
  tmn_pkg::sqrt_ctl_t sctl;
  logic [SW-1:0]   rad;
  logic [SW/2-1:0] root;
  logic            cfg_fire, in_fire, out_load;

  function automatic logic [PW-1:0] dim_m1(input logic [DW-1:0] v);
    if (v == '0) return '0;
    if (32'(v) > MAX_DIM) return PW'(MAX_DIM - 1);
    return PW'(v - 1'b1);
  endfunction

  assign rows_m1  = dim_m1(row_cnt);
  assign cols_m1  = dim_m1(col_cnt);
  assign cfg_ready = (state == tmn_pkg::ST_IDLE);
  assign cfg_fire = cfg_valid && cfg_ready;
  assign in_stall = (state != tmn_pkg::ST_IDLE) || cfg_valid;
  assign in_fire  = in_valid && !in_stall;
  assign out_load = (state == tmn_pkg::ST_OUT) && (!out_valid || !out_stall);
  assign restart  = (row_pos > rows_m1) || (col_pos > cols_m1);

  assign diag     = (row_pos == col_pos);
  assign counted  = lower ? (row_pos >= col_pos) : (row_pos <= col_pos);
  assign last_row = (row_pos == rows_m1);
  assign last_col = (col_pos == cols_m1);

  assign are    = elem_re[EW-1] ? EW'(-elem_re) : EW'(elem_re);
  assign aim    = elem_im[EW-1] ? EW'(-elem_im) : EW'(elem_im);
  assign are_sq = {{EW{1'b0}}, are} * {{EW{1'b0}}, are};
  assign aim_sq = {{EW{1'b0}}, aim} * {{EW{1'b0}}, aim};
  assign sq_el  = {1'b0, are_sq} + {1'b0, aim_sq};
  assign sctl.start = (state == tmn_pkg::ST_IDLE && in_fire) ||
                      (state == tmn_pkg::ST_ROWWR && last_col && last_row &&
                       kind == tmn_pkg::KIND_FROB);
  assign rad = (state == tmn_pkg::ST_IDLE) ? SW'(sq_el) : sq_fin;

  tmn_isqrt #(.IN_W(SW)) u_isqrt (
    .clk(clk), .rst(rst), .start(sctl.start), .radicand(rad),
    .root(root), .busy(sctl.busy), .done(sctl.done)
  );

  always_comb begin
    if (!counted) begin
      mag     = '0;
      sq_term = '0;
    end else if (unitd && diag) begin
      mag     = NW'(1) << (EW - 1);
      sq_term = SW'(1) << (2 * EW - 2);
    end else begin
      mag     = (root > (SW/2)'(tmn_pkg::NORM_MAX)) ? tmn_pkg::NORM_MAX : NW'(root);
      sq_term = sq;
    end
    col_sum = {1'b0, col_tot} + {1'b0, mag};
    col_fin = col_sum[NW] ? tmn_pkg::NORM_MAX : col_sum[NW-1:0];
    row_sum = (col_pos == '0 ? {(NW+1){1'b0}} : {1'b0, row_rd}) + {1'b0, mag};
    row_wr  = row_sum[NW] ? tmn_pkg::NORM_MAX : row_sum[NW-1:0];
    sq_sum  = {1'b0, sq_tot} + {1'b0, sq_term};
    sq_fin  = sq_sum[SW] ? {SW{1'b1}} : sq_sum[SW-1:0];
    best_next = best;
    if (kind == tmn_pkg::KIND_MAX_MAG && mag > best) best_next = mag;
    if (kind == tmn_pkg::KIND_COL_SUM && last_row && col_fin > best) best_next = col_fin;
    if (kind == tmn_pkg::KIND_ROW_SUM && last_col && row_wr > best) best_next = row_wr;
  end

  tmn_ram #(.WIDTH(NW), .DEPTH(MAX_DIM)) u_rows (
    .clk(clk), .we(state == tmn_pkg::ST_ROWWR), .addr(row_pos),
    .wdata(row_wr), .rdata(row_rd)
  );

  always_comb begin
    state_next = state;
    case (state)
      tmn_pkg::ST_IDLE:  if (in_fire) state_next = tmn_pkg::ST_MAG;
      tmn_pkg::ST_MAG:   if (sctl.done) state_next = tmn_pkg::ST_ROWRD;
      tmn_pkg::ST_ROWRD: state_next = tmn_pkg::ST_ROWWR;
      tmn_pkg::ST_ROWWR: begin
        if (last_row && last_col) begin
          state_next = (kind == tmn_pkg::KIND_FROB) ? tmn_pkg::ST_FROB : tmn_pkg::ST_OUT;
        end else begin
          state_next = tmn_pkg::ST_IDLE;
        end
      end
      tmn_pkg::ST_FROB:  if (sctl.done) state_next = tmn_pkg::ST_OUT;
      tmn_pkg::ST_OUT:   if (out_load) state_next = tmn_pkg::ST_IDLE;
      default:           state_next = tmn_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tmn_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kind    <= tmn_pkg::KIND_MAX_MAG;
      lower   <= 1'b0;
      unitd   <= 1'b0;
      row_cnt <= DW'(64);
      col_cnt <= DW'(64);
      row_pos <= '0;
      col_pos <= '0;
      best    <= '0;
      col_tot <= '0;
      sq_tot  <= '0;
    end else if (cfg_fire) begin
      case (cfg_index)
        tmn_pkg::REG_NORM_KIND:  kind    <= tmn_pkg::kind_t'(cfg_data[1:0]);
        tmn_pkg::REG_LOWER_PART: lower   <= cfg_data[0];
        tmn_pkg::REG_UNIT_DIAG:  unitd   <= cfg_data[0];
        tmn_pkg::REG_ROW_COUNT:  row_cnt <= cfg_data[DW-1:0];
        tmn_pkg::REG_COL_COUNT:  col_cnt <= cfg_data[DW-1:0];
        default: ;
      endcase
      row_pos <= '0;
      col_pos <= '0;
      best    <= '0;
      col_tot <= '0;
      sq_tot  <= '0;
    end else begin
      case (state)
        tmn_pkg::ST_IDLE: if (in_fire) begin
          sq <= SW'(sq_el);
          if (restart) begin
            row_pos <= '0;
            col_pos <= '0;
            best    <= '0;
            col_tot <= '0;
            sq_tot  <= '0;
          end
        end
        tmn_pkg::ST_ROWWR: begin
          best    <= best_next;
          col_tot <= last_row ? '0 : col_fin;
          if (last_row && last_col) begin
            sq_tot  <= '0;
            row_pos <= '0;
            col_pos <= '0;
          end else begin
            sq_tot <= sq_fin;
            if (last_row) begin
              row_pos <= '0;
              col_pos <= col_pos + 1'b1;
            end else begin
              row_pos <= row_pos + 1'b1;
            end
          end
        end
        tmn_pkg::ST_FROB: if (sctl.done) begin
          best <= (root > (SW/2)'(tmn_pkg::NORM_MAX)) ? tmn_pkg::NORM_MAX : NW'(root);
        end
        tmn_pkg::ST_OUT: if (out_load) begin
          norm_value <= best;
          best       <= '0;
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(norm_value))
    else $error("result changed while held");
  assert property (@(posedge clk) disable iff (rst)
    sctl.done |-> state == tmn_pkg::ST_MAG || state == tmn_pkg::ST_FROB)
    else $error("root finished outside a root state");
  assert property (@(posedge clk) disable iff (rst)
    in_fire |-> !sctl.busy)
    else $error("element taken while root busy");
endmodule
`default_nettype wire
